// File: sv/tss_pkg.sv
// Shared types and constants of the throttle shift scheduler.
// No dependencies; the front, queue, back and top-level files import this package.
package tss_pkg;

    localparam int TS_W        = 32;
    localparam int THR_W       = 17;
    localparam int RPM_W       = 16;
    localparam int COEF_W      = 24;
    localparam int NUM_COEF    = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 8;
    localparam int CMD_W       = 2;

    localparam int FRAC_W  = 16;
    localparam int T2_W    = 18;
    localparam int T3_W    = 20;
    localparam int MUL_A_W = COEF_W + 1;
    localparam int MUL_B_W = T3_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = 32;
    localparam int SPEED_W = RPM_W + 8;

    localparam int STEP_W    = 4;
    localparam int LAST_STEP = 8;

    localparam int QUEUE_DEPTH = 2;

    localparam int unsigned SHIFT_LATENCY_DEF = 1000;

    // coefficient register indexes
    localparam logic [CFG_IDX_W-1:0] REG_UP_C0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UP_C1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UP_C2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UP_C3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DN_C0 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DN_C1 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DN_C2 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DN_C3 = 3'd7;

    typedef logic [NUM_COEF-1:0][COEF_W-1:0] coef_bank_t;

    typedef struct packed {
        logic [TS_W-1:0]  timestamp;
        logic [THR_W-1:0] throttle;
        logic [RPM_W-1:0] engine_speed;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } item_beat_t;

    typedef struct packed {
        logic full;
        logic not_empty;
    } queue_status_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_NONE = 2'd0,
        CMD_UP   = 2'd1,
        CMD_DOWN = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_CALC,
        BK_DONE
    } back_state_t;

endpackage

// File: sv/tss_front.sv
// Front end of the shift scheduler: input beat register and field unpacking.
// Depends on tss_pkg; feeds tss_queue.
module tss_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [tss_pkg::IN_TDATA_W-1:0] s_tdata,
    input  tss_pkg::queue_status_t         q_status,
    output tss_pkg::item_beat_t            push
);
    import tss_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  accept;
    logic  drain;

    assign drain    = valid_reg && !q_status.full;
    assign s_tready = !valid_reg || drain;
    assign accept   = s_tvalid && s_tready;

    assign valid_next = accept || (valid_reg && !drain);

    assign push.valid = drain;
    assign push.item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // unpack: timestamp lowest, then throttle, then engine speed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.timestamp    <= s_tdata[TS_W-1:0];
            item_reg.throttle     <= s_tdata[TS_W+THR_W-1:TS_W];
            item_reg.engine_speed <= s_tdata[TS_W+THR_W+RPM_W-1:TS_W+THR_W];
        end
    end

endmodule

// File: sv/tss_queue.sv
// Short item queue between front and back end of the shift scheduler.
// Depends on tss_pkg.
module tss_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tss_pkg::item_beat_t    push,
    input  logic                   pop,
    output tss_pkg::item_t         head,
    output tss_pkg::queue_status_t status
);
    import tss_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t            mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign status.full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign status.not_empty = (count_reg != '0);
    assign do_push          = push.valid && !status.full;
    assign do_pop           = pop && status.not_empty;
    assign head             = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push.item;
        end
    end

endmodule

// File: sv/tss_back.sv
// Back end of the shift scheduler: Horner-free polynomial evaluation on one
// shared multiplier, latency window check and output register. Uses tss_pkg.
module tss_back #(
    parameter int unsigned SHIFT_LATENCY = tss_pkg::SHIFT_LATENCY_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  tss_pkg::coef_bank_t     coeff,
    input  tss_pkg::queue_status_t  q_status,
    input  tss_pkg::item_t          head,
    output logic                    pop,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output tss_pkg::cmd_t           cmd
);
    import tss_pkg::*;

    back_state_t              state_reg;
    back_state_t              state_next;
    logic [STEP_W-1:0]        step_reg;
    item_t                    item_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [T2_W-1:0]          t2_reg;
    logic [T3_W-1:0]          t3_reg;
    logic signed [ACC_W-1:0]  acc_up_reg;
    logic signed [ACC_W-1:0]  acc_dn_reg;
    logic [TS_W-1:0]          last_shift_reg;
    logic                     out_valid_reg;
    cmd_t                     out_cmd_reg;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [ACC_W-1:0]   term;
    logic signed [ACC_W-1:0]   speed;
    logic [TS_W-1:0]           age;
    logic                      out_free;
    logic                      fire;
    cmd_t                      decision;

    function automatic logic signed [MUL_A_W-1:0] coef_op(input logic [COEF_W-1:0] c);
        coef_op = $signed({c[COEF_W-1], c});
    endfunction

    function automatic logic signed [ACC_W-1:0] coef_acc(input logic [COEF_W-1:0] c);
        coef_acc = ACC_W'($signed(c));
    endfunction

    // operand select per step; in BK_CALC the product lands in prod_reg in the following cycle
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (step_reg)
            4'd0:
            begin
                mul_a = $signed(MUL_A_W'(item_reg.throttle));
                mul_b = $signed(MUL_B_W'(item_reg.throttle));
            end
            4'd1:
            begin
                mul_a = $signed(MUL_A_W'(item_reg.throttle));
                mul_b = $signed(MUL_B_W'(prod_reg[FRAC_W+T2_W-1:FRAC_W]));
            end
            4'd2:
            begin
                mul_a = coef_op(coeff[REG_UP_C1]);
                mul_b = $signed(MUL_B_W'(item_reg.throttle));
            end
            4'd3:
            begin
                mul_a = coef_op(coeff[REG_UP_C2]);
                mul_b = $signed(MUL_B_W'(t2_reg));
            end
            4'd4:
            begin
                mul_a = coef_op(coeff[REG_UP_C3]);
                mul_b = $signed(MUL_B_W'(t3_reg));
            end
            4'd5:
            begin
                mul_a = coef_op(coeff[REG_DN_C1]);
                mul_b = $signed(MUL_B_W'(item_reg.throttle));
            end
            4'd6:
            begin
                mul_a = coef_op(coeff[REG_DN_C2]);
                mul_b = $signed(MUL_B_W'(t2_reg));
            end
            4'd7:
            begin
                mul_a = coef_op(coeff[REG_DN_C3]);
                mul_b = $signed(MUL_B_W'(t3_reg));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;
    // floor division by 65536 of a signed product
    assign term      = ACC_W'(prod_reg >>> FRAC_W);

    assign speed = $signed(ACC_W'({item_reg.engine_speed, 8'd0}));
    assign age   = item_reg.timestamp - last_shift_reg;

    always_comb
    begin
        decision = CMD_NONE;
        if (age >= TS_W'(SHIFT_LATENCY))
        begin
            if (speed > acc_up_reg)
            begin
                decision = CMD_UP;
            end
            else if (speed < acc_dn_reg)
            begin
                decision = CMD_DOWN;
            end
        end
    end

    assign out_free = !out_valid_reg || m_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_status.not_empty)
                begin
                    state_next = BK_CALC;
                end
            end
            BK_CALC:
            begin
                if (step_reg == STEP_W'(LAST_STEP))
                begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        pop  = 1'b0;
        fire = 1'b0;
        case (state_reg)
            BK_IDLE: pop  = q_status.not_empty;
            BK_CALC: pop  = 1'b0;
            BK_DONE: fire = out_free;
            default:
            begin
                pop  = 1'b0;
                fire = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_IDLE;
            step_reg       <= '0;
            last_shift_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop)
            begin
                step_reg <= '0;
            end
            else if (state_reg == BK_CALC)
            begin
                step_reg <= step_reg + 1'b1;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
                if (decision != CMD_NONE)
                begin
                    last_shift_reg <= item_reg.timestamp;
                end
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg   <= head;
            acc_up_reg <= coef_acc(coeff[REG_UP_C0]);
            acc_dn_reg <= coef_acc(coeff[REG_DN_C0]);
        end
        if (state_reg == BK_CALC)
        begin
            prod_reg <= prod_next;
            case (step_reg)
                4'd1:    t2_reg <= prod_reg[FRAC_W+T2_W-1:FRAC_W];
                4'd2:    t3_reg <= prod_reg[FRAC_W+T3_W-1:FRAC_W];
                4'd3,
                4'd4,
                4'd5:    acc_up_reg <= acc_up_reg + term;
                4'd6,
                4'd7,
                4'd8:    acc_dn_reg <= acc_dn_reg + term;
                default: ;
            endcase
        end
        if (fire)
        begin
            out_cmd_reg <= decision;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign cmd      = out_cmd_reg;

endmodule

// File: sv/throttle_shift_scheduler.sv
// Top level of the throttle shift scheduler: coefficient registers and the
// front end, queue and back end. Depends on tss_pkg, tss_front, tss_queue, tss_back.
//
// Each input beat carries a timestamp, a throttle position (Q1.16, full at
// 65536, larger values used as given) and the engine speed in rpm. The block
// evaluates the up-shift and down-shift threshold cubics in throttle with
// eight passes through a single 25x21-bit signed multiplier, then commands
// an up-shift when rpm*256 is above the up threshold, else a down-shift when
// below the down threshold, but only once SHIFT_LATENCY ticks (modular) have
// passed since the last commanded shift. Exactly one result beat comes out
// per input beat, in order. The back end takes one item at a time: it picks
// the item from the queue, runs nine calculation steps that issue the eight
// products and add the last one into its threshold, then decides, waiting
// while the output is stalled, and only then takes the next item from the queue.
// The input register plus a two-deep queue hold up to three items while the
// back end works or the output is stalled. Write the eight coefficient
// registers only while the block is idle; they reset to zero.
module throttle_shift_scheduler #(
    parameter int unsigned SHIFT_LATENCY = tss_pkg::SHIFT_LATENCY_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // coefficient write port
    input  logic                            cfg_we,
    input  logic [tss_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tss_pkg::COEF_W-1:0]      cfg_data,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata: timestamp[31:0], throttle[48:32], engine_speed[64:49], zero pad
    input  logic [tss_pkg::IN_TDATA_W-1:0]  s_tdata,
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata: shift_command[1:0], zero pad
    output logic [tss_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import tss_pkg::*;

    coef_bank_t    coeff_reg;
    item_beat_t    push;
    queue_status_t q_status;
    item_t         head;
    logic          pop;
    cmd_t          cmd;

    // coefficient bank: every index of the 3-bit port maps to a register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_reg <= '0;
        end
        else if (cfg_we)
        begin
            coeff_reg[cfg_index] <= cfg_data;
        end
    end

    // front: register and unpack the incoming beat
    tss_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_status (q_status),
        .push     (push)
    );

    // decouple front and back so either side can stall on its own
    tss_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .pop    (pop),
        .head   (head),
        .status (q_status)
    );

    // back: evaluate thresholds, apply latency window, hold the result
    tss_back #(
        .SHIFT_LATENCY (SHIFT_LATENCY)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .coeff    (coeff_reg),
        .q_status (q_status),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    assign m_tdata = {(OUT_TDATA_W - CMD_W)'(0), cmd};

endmodule

// File: sv/tss_checker.sv
// Port-level checks for the throttle shift scheduler, bound to the top level.
// Depends on throttle_shift_scheduler.
module tss_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // a result code is none, up or down
    a_cmd_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[1:0] != 2'd3))
        else $error("shift command outside the defined codes");

    // padding above the command stays zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[7:2] == 6'd0))
        else $error("result padding bits not zero");

    // no result may appear straight out of reset
    a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !m_tvalid)
        else $error("result beat valid right after reset");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result beat changed or dropped");

endmodule

bind throttle_shift_scheduler tss_checker u_tss_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
